@@ rtl/plti_pkg.sv @@
// ----------------------------------------------------------------------------
// plti_pkg: shared types and constants of the breakpoint table interpolator
// Field widths, command codes, request and response structs, sequencer states.
// ----------------------------------------------------------------------------
package plti_pkg;

  localparam int GAUGE_W  = 24;
  localparam int WEIGHT_W = 32;
  localparam int IDX_W    = 4;
  localparam int TSEL_W   = 2;
  localparam int CNT_W    = 5;
  localparam int RES_W    = 34;
  localparam int ENTRY_W  = GAUGE_W + WEIGHT_W;

  // number of breakpoint tables held in the memory
  localparam int NUM_TABLES = 3;

  // command kind carried in the input tuser
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // table selector that names no table
  localparam logic [TSEL_W-1:0] TSEL_NONE = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_COUNT_PLAIN = 2'd0;
  localparam logic [1:0] CFG_COUNT_WOUND = 2'd1;
  localparam logic [1:0] CFG_COUNT_HEAVY = 2'd2;

  typedef struct packed {
    logic [GAUGE_W-1:0] gauge;
    logic [TSEL_W-1:0]  table_sel;
    logic [CNT_W-1:0]   count;      // already clamped to the legal range
  } plti_req_t;

  typedef struct packed {
    logic [RES_W-1:0] unit_weight;
    logic             saturated;
  } plti_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_SETUP,
    ST_DIV,
    ST_MUL,
    ST_ROUND,
    ST_SUM,
    ST_OUT
  } plti_state_e;

endpackage

@@ rtl/piecewise_linear_table_interpolator_top.sv @@
// ----------------------------------------------------------------------------
// piecewise_linear_table_interpolator_top: breakpoint table interpolator
// Three (gauge, weight) breakpoint tables with a serial query engine.
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one command per transaction; tuser bit 0 picks load or
//   query, tuser bits 2:1 pick the table. a load writes one breakpoint into
//   the table memory in the accept cycle and produces no result. a query
//   yields exactly one m_axis transaction with the interpolated weight in
//   tdata and the saturation flag in tuser.
//   cfg_we_i / cfg_idx_i / cfg_data_i set the breakpoint counts of the three
//   tables; write them only while no query is in flight.
// timing
//   a query walks the table with a registered memory read and then a compare
//   for each entry visited, then runs a setup step, a restoring divide of
//   32 + SLOPE_FRAC_BITS steps and a 24-step shift-add multiply on one shared
//   adder, and then rounding, sum and handoff. the divide is skipped when
//   both ends of the segment share one gauge. an exact breakpoint hit answers
//   right after its compare. zero gauge or table 3 goes straight from the
//   accept to the handoff. s_axis_tready is low while a query runs.
// reset and stall
//   reset returns the counts to 2 and empties the output register; table
//   contents are undefined until loaded. the result sits in an output
//   register, so a new command is taken while m_axis is stalled; a second
//   query then waits with its result until the register drains.
// ----------------------------------------------------------------------------
module piecewise_linear_table_interpolator_top #(
  parameter int TABLE_DEPTH     = 16,
  parameter int SLOPE_FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // commands
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // entry_index[3:0], gauge[27:4], weight[59:28]
  input  logic [2:0]  s_axis_tuser,   // mode[0], table_sel[2:1]
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // unit_weight[33:0]
  output logic [0:0]  m_axis_tuser,   // saturated[0]
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [4:0]  cfg_data_i
);

  localparam int DEPTH = plti_pkg::NUM_TABLES * TABLE_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  // command fields
  logic                            in_mode;
  logic [plti_pkg::TSEL_W-1:0]     in_tsel;
  logic [plti_pkg::IDX_W-1:0]      in_idx;
  logic [plti_pkg::GAUGE_W-1:0]    in_gauge;
  logic [plti_pkg::WEIGHT_W-1:0]   in_weight;

  assign in_mode   = s_axis_tuser[0];
  assign in_tsel   = s_axis_tuser[2:1];
  assign in_idx    = s_axis_tdata[3:0];
  assign in_gauge  = s_axis_tdata[27:4];
  assign in_weight = s_axis_tdata[59:28];

  // breakpoint counts
  logic [plti_pkg::CNT_W-1:0] cnt_plain_q, cnt_wound_q, cnt_heavy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_plain_q <= plti_pkg::CNT_W'(2);
      cnt_wound_q <= plti_pkg::CNT_W'(2);
      cnt_heavy_q <= plti_pkg::CNT_W'(2);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        plti_pkg::CFG_COUNT_PLAIN: cnt_plain_q <= cfg_data_i;
        plti_pkg::CFG_COUNT_WOUND: cnt_wound_q <= cfg_data_i;
        plti_pkg::CFG_COUNT_HEAVY: cnt_heavy_q <= cfg_data_i;
        default: ;   // no register at this index
      endcase
    end
  end

  // count of the selected table, clamped to [2, TABLE_DEPTH]
  logic [plti_pkg::CNT_W-1:0] cnt_sel, cnt_clamped;

  always_comb begin
    unique case (in_tsel)
      plti_pkg::CFG_COUNT_WOUND: cnt_sel = cnt_wound_q;
      plti_pkg::CFG_COUNT_HEAVY: cnt_sel = cnt_heavy_q;
      default:                   cnt_sel = cnt_plain_q;
    endcase
    if (cnt_sel < plti_pkg::CNT_W'(2)) begin
      cnt_clamped = plti_pkg::CNT_W'(2);
    end else if (32'(cnt_sel) > TABLE_DEPTH) begin
      cnt_clamped = plti_pkg::CNT_W'(TABLE_DEPTH);
    end else begin
      cnt_clamped = cnt_sel;
    end
  end

  // command handshake
  logic core_idle, in_xfer, load_xfer, query_xfer, ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [plti_pkg::ENTRY_W-1:0] ram_rdata;

  assign s_axis_tready = core_idle;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign load_xfer     = in_xfer && (in_mode == plti_pkg::MODE_LOAD);
  assign query_xfer    = in_xfer && (in_mode == plti_pkg::MODE_QUERY);

  // loads to table 3 or past the table depth are dropped
  assign ram_we    = load_xfer && (in_tsel != plti_pkg::TSEL_NONE)
                     && (32'(in_idx) < TABLE_DEPTH);
  assign ram_waddr = AW'(in_tsel) * AW'(TABLE_DEPTH) + AW'(in_idx);

  plti_ram #(
    .WIDTH(plti_pkg::ENTRY_W),
    .DEPTH(DEPTH)
  ) u_table_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i({in_weight, in_gauge}),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // query engine
  plti_pkg::plti_req_t core_req;
  plti_pkg::plti_rsp_t core_rsp;
  logic                core_rsp_valid, core_rsp_ready;

  assign core_req = '{gauge: in_gauge, table_sel: in_tsel, count: cnt_clamped};

  plti_core #(
    .TABLE_DEPTH    (TABLE_DEPTH),
    .SLOPE_FRAC_BITS(SLOPE_FRAC_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (query_xfer),
    .req_i      (core_req),
    .idle_o     (core_idle),
    .rsp_valid_o(core_rsp_valid),
    .rsp_ready_i(core_rsp_ready),
    .rsp_o      (core_rsp),
    .rd_addr_o  (ram_raddr),
    .rd_data_i  (ram_rdata)
  );

  // output register, refilled as it drains
  logic                out_valid_q;
  plti_pkg::plti_rsp_t out_data_q;

  assign core_rsp_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (core_rsp_valid && core_rsp_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_rsp_valid && core_rsp_ready) begin
      out_data_q <= core_rsp;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = 40'(out_data_q.unit_weight);
  assign m_axis_tuser  = out_data_q.saturated;

`ifndef ASSERT_OFF
  // an accepted query always starts the engine
  a_query_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    query_xfer |=> !s_axis_tready)
    else $error("query accepted but engine stayed idle");

  // a load never wakes the engine
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_xfer |=> s_axis_tready)
    else $error("load transaction started the query engine");

  // engine holds its result while the output register is full
  a_rsp_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (core_rsp_valid && out_valid_q && !m_axis_tready) |=> core_rsp_valid)
    else $error("result dropped while output register was full");

  // a saturated result sits at one of the range limits
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      (m_axis_tdata[33:0] == 34'h1_FFFF_FFFF || m_axis_tdata[33:0] == 34'h2_0000_0000))
    else $error("saturation flag set on an unclamped weight");
`endif

endmodule

@@ rtl/plti_ram.sv @@
// ----------------------------------------------------------------------------
// plti_ram: generic single-write, single-read memory
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module plti_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/plti_alu.sv @@
// ----------------------------------------------------------------------------
// plti_alu: shared adder / subtractor
// Serves the restoring divide steps and the shift-add multiply steps.
// ----------------------------------------------------------------------------
module plti_alu #(
  parameter int WIDTH = 33
) (
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  input  logic             sub_i,
  output logic [WIDTH-1:0] sum_o
);

  assign sum_o = sub_i ? (a_i - b_i) : (a_i + b_i);

endmodule

@@ rtl/plti_core.sv @@
// ----------------------------------------------------------------------------
// plti_core: query sequencer
// Walks one table for the bracketing pair, then divides and multiplies
// bit-serially through the shared alu and saturates the result.
// ----------------------------------------------------------------------------
module plti_core #(
  parameter int TABLE_DEPTH     = 16,
  parameter int SLOPE_FRAC_BITS = 16
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           start_i,
  input  plti_pkg::plti_req_t                            req_i,
  output logic                                           idle_o,
  output logic                                           rsp_valid_o,
  input  logic                                           rsp_ready_i,
  output plti_pkg::plti_rsp_t                            rsp_o,
  output logic [$clog2(plti_pkg::NUM_TABLES*TABLE_DEPTH)-1:0] rd_addr_o,
  input  logic [plti_pkg::ENTRY_W-1:0]                   rd_data_i
);

  localparam int AW        = $clog2(plti_pkg::NUM_TABLES * TABLE_DEPTH);
  localparam int GW        = plti_pkg::GAUGE_W;
  localparam int WW        = plti_pkg::WEIGHT_W;
  localparam int QW        = WW + SLOPE_FRAC_BITS;   // quotient / dividend width
  localparam int AL_W      = QW + 1;
  localparam int MUL_STEPS = GW;
  localparam int PW        = AL_W + GW;              // full product width
  localparam int CW        = $clog2(QW);
  localparam int RM_W      = 41;
  localparam int SUM_W     = 43;

  localparam logic [PW-1:0] FRAC_MASK = (PW'(1) << SLOPE_FRAC_BITS) - PW'(1);
  localparam logic [PW-1:0] TERM_CAP  = PW'(1) << 40;
  localparam logic signed [SUM_W-1:0] SUM_MAX = (SUM_W'(1) << 33) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] SUM_MIN = -(SUM_W'(1) << 33);

  plti_pkg::plti_state_e state_q, state_d;

  logic [GW-1:0]               gauge_q, gauge_d;
  logic [plti_pkg::TSEL_W-1:0] tsel_q, tsel_d;
  logic [plti_pkg::CNT_W-1:0]  n_q, n_d;
  logic [plti_pkg::CNT_W-1:0]  k_q, k_d;
  logic                        first_q, first_d;
  logic [GW-1:0]               lo_g_q, lo_g_d, hi_g_q, hi_g_d;
  logic [WW-1:0]               lo_w_q, lo_w_d, hi_w_q, hi_w_d;
  logic [GW-1:0]               dgm_q, dgm_d;
  logic                        neg_q, neg_d;
  logic [WW-1:0]               wa_q, wa_d;
  logic [GW-1:0]               rem_q, rem_d;
  logic [QW-1:0]               quo_q, quo_d;
  logic [CW-1:0]               cnt_q, cnt_d;
  logic [AL_W-1:0]             acc_q, acc_d;
  logic [GW-1:0]               mlo_q, mlo_d;
  logic [RM_W-1:0]             rm_q, rm_d;
  logic [plti_pkg::RES_W-1:0]  res_q, res_d;
  logic                        sat_q, sat_d;

  // entry read back from the table memory
  logic [GW-1:0] ent_g;
  logic [WW-1:0] ent_w;
  logic          ent_lt, ent_eq, k_last, trivial;

  assign ent_g   = rd_data_i[GW-1:0];
  assign ent_w   = rd_data_i[plti_pkg::ENTRY_W-1:GW];
  assign ent_lt  = gauge_q < ent_g;
  assign ent_eq  = gauge_q == ent_g;
  assign k_last  = k_q == (n_q - plti_pkg::CNT_W'(1));
  assign trivial = (req_i.gauge == '0) || (req_i.table_sel == plti_pkg::TSEL_NONE);

  // segment setup: slope sign, anchor end and distance from it
  logic signed [GW:0]   dg, da_hi, da_lo, dx;
  logic signed [WW:0]   dw;
  logic [GW-1:0]        dg_mag, dah_mag, dal_mag, dx_mag, g_anchor;
  logic [WW-1:0]        dw_mag;
  logic                 dg_zero, qneg, use_hi;

  assign dg      = $signed({1'b0, hi_g_q}) - $signed({1'b0, lo_g_q});
  assign dw      = $signed({1'b0, hi_w_q}) - $signed({1'b0, lo_w_q});
  assign dg_mag  = dg[GW] ? GW'(-dg) : dg[GW-1:0];
  assign dw_mag  = dw[WW] ? WW'(-dw) : dw[WW-1:0];
  assign dg_zero = dg == '0;
  assign qneg    = !dg_zero && (dw[WW] != dg[GW]);
  assign da_hi   = $signed({1'b0, gauge_q}) - $signed({1'b0, hi_g_q});
  assign da_lo   = $signed({1'b0, gauge_q}) - $signed({1'b0, lo_g_q});
  assign dah_mag = da_hi[GW] ? GW'(-da_hi) : da_hi[GW-1:0];
  assign dal_mag = da_lo[GW] ? GW'(-da_lo) : da_lo[GW-1:0];
  assign use_hi  = dah_mag < dal_mag;
  assign g_anchor = use_hi ? hi_g_q : lo_g_q;
  assign dx      = $signed({1'b0, gauge_q}) - $signed({1'b0, g_anchor});
  assign dx_mag  = dx[GW] ? GW'(-dx) : dx[GW-1:0];

  // shared alu
  logic [AL_W-1:0] alu_a, alu_b, alu_sum;
  logic            alu_sub;

  plti_alu #(
    .WIDTH(AL_W)
  ) u_alu (
    .a_i  (alu_a),
    .b_i  (alu_b),
    .sub_i(alu_sub),
    .sum_o(alu_sum)
  );

  logic div_ge;
  assign div_ge = !alu_sum[AL_W-1];

  // rounding of the product and final sum
  logic [PW-1:0]           prod, mag, mag_up;
  logic                    sticky;
  logic [SUM_W-1:0]        term_abs, term, sum;

  assign prod     = {acc_q, mlo_q};
  assign sticky   = |(prod & FRAC_MASK);
  assign mag      = prod >> SLOPE_FRAC_BITS;
  assign mag_up   = mag + PW'(neg_q & sticky);
  assign term_abs = SUM_W'(rm_q);
  assign term     = neg_q ? -term_abs : term_abs;
  assign sum      = SUM_W'(wa_q) + term;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      plti_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = trivial ? plti_pkg::ST_OUT : plti_pkg::ST_RD;
        end
      end
      plti_pkg::ST_RD:  state_d = plti_pkg::ST_CMP;
      plti_pkg::ST_CMP: begin
        if (first_q) begin
          state_d = plti_pkg::ST_SETUP;
        end else if (ent_lt) begin
          state_d = (k_q == '0) ? plti_pkg::ST_RD : plti_pkg::ST_SETUP;
        end else if (ent_eq) begin
          state_d = plti_pkg::ST_OUT;
        end else if (k_last) begin
          state_d = plti_pkg::ST_SETUP;
        end else begin
          state_d = plti_pkg::ST_RD;
        end
      end
      plti_pkg::ST_SETUP: state_d = dg_zero ? plti_pkg::ST_MUL : plti_pkg::ST_DIV;
      plti_pkg::ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = plti_pkg::ST_MUL;
        end
      end
      plti_pkg::ST_MUL: begin
        if (cnt_q == '0) begin
          state_d = plti_pkg::ST_ROUND;
        end
      end
      plti_pkg::ST_ROUND: state_d = plti_pkg::ST_SUM;
      plti_pkg::ST_SUM:   state_d = plti_pkg::ST_OUT;
      plti_pkg::ST_OUT: begin
        if (rsp_ready_i) begin
          state_d = plti_pkg::ST_IDLE;
        end
      end
      default: state_d = plti_pkg::ST_IDLE;
    endcase
  end

  // outputs and alu control
  always_comb begin
    idle_o      = 1'b0;
    rsp_valid_o = 1'b0;
    alu_a       = '0;
    alu_b       = '0;
    alu_sub     = 1'b0;
    unique case (state_q)
      plti_pkg::ST_IDLE: idle_o = 1'b1;
      plti_pkg::ST_DIV: begin
        alu_a   = AL_W'({rem_q, quo_q[QW-1]});
        alu_b   = AL_W'(dgm_q);
        alu_sub = 1'b1;
      end
      plti_pkg::ST_MUL: begin
        alu_a = acc_q;
        alu_b = mlo_q[0] ? AL_W'(quo_q) : '0;
      end
      plti_pkg::ST_OUT: rsp_valid_o = 1'b1;
      default: ;
    endcase
  end

  assign rd_addr_o = AW'(tsel_q) * AW'(TABLE_DEPTH) + AW'(k_q);
  assign rsp_o     = '{unit_weight: res_q, saturated: sat_q};

  // datapath
  always_comb begin
    gauge_d = gauge_q;
    tsel_d  = tsel_q;
    n_d     = n_q;
    k_d     = k_q;
    first_d = first_q;
    lo_g_d  = lo_g_q;
    lo_w_d  = lo_w_q;
    hi_g_d  = hi_g_q;
    hi_w_d  = hi_w_q;
    dgm_d   = dgm_q;
    neg_d   = neg_q;
    wa_d    = wa_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    mlo_d   = mlo_q;
    rm_d    = rm_q;
    res_d   = res_q;
    sat_d   = sat_q;
    case (state_q)
      plti_pkg::ST_IDLE: begin
        if (start_i) begin
          gauge_d = req_i.gauge;
          tsel_d  = req_i.table_sel;
          n_d     = req_i.count;
          k_d     = '0;
          first_d = 1'b0;
          res_d   = '0;
          sat_d   = 1'b0;
        end
      end
      plti_pkg::ST_CMP: begin
        if (first_q) begin
          hi_g_d = ent_g;
          hi_w_d = ent_w;
        end else if (ent_lt) begin
          if (k_q == '0) begin
            // below the first breakpoint: extrapolate from entries 0 and 1
            lo_g_d  = ent_g;
            lo_w_d  = ent_w;
            first_d = 1'b1;
            k_d     = plti_pkg::CNT_W'(1);
          end else begin
            hi_g_d = ent_g;
            hi_w_d = ent_w;
          end
        end else if (ent_eq) begin
          res_d = plti_pkg::RES_W'(ent_w);
        end else if (k_last) begin
          hi_g_d = ent_g;
          hi_w_d = ent_w;
        end else begin
          lo_g_d = ent_g;
          lo_w_d = ent_w;
          k_d    = k_q + plti_pkg::CNT_W'(1);
        end
      end
      plti_pkg::ST_SETUP: begin
        dgm_d = dg_mag;
        neg_d = dx[GW] ^ qneg;
        wa_d  = use_hi ? hi_w_q : lo_w_q;
        rem_d = '0;
        quo_d = dg_zero ? '0 : (QW'(dw_mag) << SLOPE_FRAC_BITS);
        cnt_d = dg_zero ? CW'(MUL_STEPS - 1) : CW'(QW - 1);
        acc_d = '0;
        mlo_d = dx_mag;
      end
      plti_pkg::ST_DIV: begin
        rem_d = div_ge ? alu_sum[GW-1:0] : {rem_q[GW-2:0], quo_q[QW-1]};
        quo_d = {quo_q[QW-2:0], div_ge};
        cnt_d = (cnt_q == '0) ? CW'(MUL_STEPS - 1) : cnt_q - CW'(1);
      end
      plti_pkg::ST_MUL: begin
        acc_d = alu_sum >> 1;
        mlo_d = {alu_sum[0], mlo_q[GW-1:1]};
        cnt_d = cnt_q - CW'(1);
      end
      plti_pkg::ST_ROUND: begin
        rm_d = (mag_up > TERM_CAP) ? RM_W'(TERM_CAP) : mag_up[RM_W-1:0];
      end
      plti_pkg::ST_SUM: begin
        if ($signed(sum) > SUM_MAX) begin
          res_d = plti_pkg::RES_W'(SUM_MAX);
          sat_d = 1'b1;
        end else if ($signed(sum) < SUM_MIN) begin
          res_d = plti_pkg::RES_W'(SUM_MIN);
          sat_d = 1'b1;
        end else begin
          res_d = sum[plti_pkg::RES_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= plti_pkg::ST_IDLE;
      k_q     <= '0;
      first_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      first_q <= first_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gauge_q <= gauge_d;
    tsel_q  <= tsel_d;
    n_q     <= n_d;
    lo_g_q  <= lo_g_d;
    lo_w_q  <= lo_w_d;
    hi_g_q  <= hi_g_d;
    hi_w_q  <= hi_w_d;
    dgm_q   <= dgm_d;
    neg_q   <= neg_d;
    wa_q    <= wa_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    acc_q   <= acc_d;
    mlo_q   <= mlo_d;
    rm_q    <= rm_d;
    res_q   <= res_d;
    sat_q   <= sat_d;
  end

endmodule

@@ tb/sv/tb_piecewise_linear_table_interpolator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_piecewise_linear_table_interpolator_top: self-checking breakpoint table bench
// Loads the three breakpoint tables, sweeps the counts and fires queries.
// Every accepted query goes through a fixed-point interpolation predictor,
// and every result transaction is checked field by field against it.
// ----------------------------------------------------------------------------
module tb_piecewise_linear_table_interpolator_top;

  localparam int TABLE_DEPTH     = 16;
  localparam int SLOPE_FRAC      = 16;
  // longest query: full table walk, divide, multiply and handoff, with margin
  localparam int SETTLE_CYCLES   = 160;
  localparam int DRAIN_LIMIT     = 20000;
  localparam int SINK_HOLD       = 400;
  localparam int NUM_PHASES      = 12;
  localparam int ITEMS_PER_PHASE = 120;

  // register index that names no register
  localparam logic [1:0] CFG_IDX_UNUSED = 2'd3;

  localparam longint          RES_MAX  = 64'sd8589934591;
  localparam longint          RES_MIN  = -64'sd8589934592;
  localparam logic [127:0]    TERM_CAP = 128'd1 << 40;

  typedef struct packed {
    logic                          mode;
    logic [plti_pkg::TSEL_W-1:0]   table_sel;
    logic [plti_pkg::IDX_W-1:0]    entry_index;
    logic [plti_pkg::GAUGE_W-1:0]  gauge;
    logic [plti_pkg::WEIGHT_W-1:0] weight;
  } plti_cmd_t;

  // --------------------------------------------------------------------------
  // breakpoint table mirror plus queue of predicted weights
  // --------------------------------------------------------------------------
  class weight_scoreboard;
    logic [plti_pkg::GAUGE_W-1:0]  gauge_mem [plti_pkg::NUM_TABLES][TABLE_DEPTH];
    logic [plti_pkg::WEIGHT_W-1:0] weight_mem[plti_pkg::NUM_TABLES][TABLE_DEPTH];
    logic [plti_pkg::CNT_W-1:0]    count_reg [plti_pkg::NUM_TABLES];
    plti_pkg::plti_rsp_t           expected_q[$];
    int                            errors;

    function new();
      foreach (count_reg[t]) count_reg[t] = 5'd2;
      errors = 0;
    endfunction

    function void set_count(logic [1:0] idx, logic [plti_pkg::CNT_W-1:0] value);
      case (idx)
        plti_pkg::CFG_COUNT_PLAIN: count_reg[0] = value;
        plti_pkg::CFG_COUNT_WOUND: count_reg[1] = value;
        plti_pkg::CFG_COUNT_HEAVY: count_reg[2] = value;
        default: ;
      endcase
    endfunction

    // counts outside 2..TABLE_DEPTH act as the nearest limit
    function int table_count(int t);
      int n;
      n = count_reg[t];
      if (n < 2) n = 2;
      if (n > TABLE_DEPTH) n = TABLE_DEPTH;
      return n;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // line through entries lo_i and hi_i, anchored at the nearer end
    function longint interp_line(int t, int lo_i, int hi_i, longint g, output bit sat);
      longint       gl, gh, wl, wh, dg, dw, abs_dw, abs_dg;
      longint       da_hi, da_lo, ga, wa, dx, term, sum;
      logic [63:0]  slope_mag, dx_mag, term_mag;
      logic [127:0] prod;
      bit           slope_neg, neg;
      sat = 1'b0;
      gl = gauge_mem[t][lo_i];
      gh = gauge_mem[t][hi_i];
      wl = weight_mem[t][lo_i];
      wh = weight_mem[t][hi_i];
      dg = gh - gl;
      dw = wh - wl;
      slope_mag = '0;
      slope_neg = 1'b0;
      if (dg != 0) begin
        abs_dw    = (dw < 0) ? -dw : dw;
        abs_dg    = (dg < 0) ? -dg : dg;
        slope_mag = (abs_dw << SLOPE_FRAC) / abs_dg;
        slope_neg = (dw < 0) != (dg < 0);
      end
      da_hi = g - gh;
      da_lo = g - gl;
      if (da_hi < 0) da_hi = -da_hi;
      if (da_lo < 0) da_lo = -da_lo;
      // ties anchor at the low end
      if (da_hi < da_lo) begin
        ga = gh;
        wa = wh;
      end else begin
        ga = gl;
        wa = wl;
      end
      dx     = g - ga;
      dx_mag = (dx < 0) ? -dx : dx;
      neg    = (dx < 0) != slope_neg;
      prod   = 128'(dx_mag) * 128'(slope_mag);
      // arithmetic shift of a negative product rounds the magnitude up
      if (neg && prod != 0) prod = prod + ((128'd1 << SLOPE_FRAC) - 1);
      prod     = prod >> SLOPE_FRAC;
      term_mag = (prod > TERM_CAP) ? TERM_CAP[63:0] : prod[63:0];
      term     = neg ? -longint'(term_mag) : longint'(term_mag);
      sum      = wa + term;
      if (sum > RES_MAX) begin
        sat = 1'b1;
        return RES_MAX;
      end
      if (sum < RES_MIN) begin
        sat = 1'b1;
        return RES_MIN;
      end
      return sum;
    endfunction

    function plti_pkg::plti_rsp_t predict_weight(int t, logic [plti_pkg::GAUGE_W-1:0] g);
      plti_pkg::plti_rsp_t rsp;
      longint              v;
      bit                  sat, done;
      int                  n;
      rsp = '0;
      if (g == 0 || t >= plti_pkg::NUM_TABLES) return rsp;
      n    = table_count(t);
      sat  = 1'b0;
      done = 1'b0;
      v    = 0;
      if (g < gauge_mem[t][0]) begin
        v    = interp_line(t, 0, 1, g, sat);
        done = 1'b1;
      end
      for (int i = 0; i + 1 < n && !done; i++) begin
        if (g == gauge_mem[t][i]) begin
          v    = weight_mem[t][i];
          done = 1'b1;
        end else if (g < gauge_mem[t][i+1]) begin
          v    = interp_line(t, i, i + 1, g, sat);
          done = 1'b1;
        end
      end
      if (!done) begin
        if (g == gauge_mem[t][n-1]) v = weight_mem[t][n-1];
        else v = interp_line(t, n - 2, n - 1, g, sat);
      end
      rsp.unit_weight = v[plti_pkg::RES_W-1:0];
      rsp.saturated   = sat;
      return rsp;
    endfunction

    // accepted command: loads update the mirror, queries queue a prediction
    function void note_command(plti_cmd_t c);
      if (c.mode == plti_pkg::MODE_LOAD) begin
        if (c.table_sel != plti_pkg::TSEL_NONE) begin
          gauge_mem[c.table_sel][c.entry_index]  = c.gauge;
          weight_mem[c.table_sel][c.entry_index] = c.weight;
        end
      end else begin
        expected_q.push_back(predict_weight(c.table_sel, c.gauge));
      end
    endfunction

    function void check_result(logic [plti_pkg::RES_W-1:0] unit_weight, logic saturated);
      plti_pkg::plti_rsp_t exp_rsp;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: unit_weight %h saturated %b",
                 $time, unit_weight, saturated);
        return;
      end
      exp_rsp = expected_q.pop_front();
      if (unit_weight !== exp_rsp.unit_weight) begin
        errors++;
        $display("%0t: unit_weight mismatch: expected %h, actual %h",
                 $time, exp_rsp.unit_weight, unit_weight);
      end
      if (saturated !== exp_rsp.saturated) begin
        errors++;
        $display("%0t: saturated mismatch: expected %b, actual %b",
                 $time, exp_rsp.saturated, saturated);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block inputs, all known from time zero
  // --------------------------------------------------------------------------
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;   // entry_index[3:0], gauge[27:4], weight[59:28]
  logic [2:0]  s_axis_tuser  = '0;   // mode[0], table_sel[2:1]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;         // unit_weight[33:0]
  logic [0:0]  m_axis_tuser;         // saturated[0]
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_idx_i     = '0;
  logic [4:0]  cfg_data_i    = '0;

  weight_scoreboard sb;

  // stimulus side bookkeeping
  bit loaded[plti_pkg::NUM_TABLES][TABLE_DEPTH];
  bit quiet;         // last part of the run: no idling on either side
  bit hold_sink;     // ask the result side for one long hold-off
  bit sender_calm;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  piecewise_linear_table_interpolator_top #(
    .TABLE_DEPTH    (TABLE_DEPTH),
    .SLOPE_FRAC_BITS(SLOPE_FRAC)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  // result transactions are checked at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata[plti_pkg::RES_W-1:0], m_axis_tuser[0]);
  end

  // result side: random stall bursts, calm stretches, one long hold-off
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned held;
    bit          calm;
    stall_left = 0;
    calm       = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_sink) begin
        // the block fills its output register and then stalls its input
        m_axis_tready = 1'b0;
        held = 0;
        while (held < SINK_HOLD) begin
          @(negedge clk_i);
          held++;
        end
        hold_sink = 1'b0;
      end
      if ($urandom_range(0, 99) == 0) calm = !calm;
      if (stall_left != 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
        m_axis_tready = 1'b0;
        stall_left    = $urandom_range(0, 4);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // give up on a hung block
  initial begin : watchdog
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // drive helpers
  // --------------------------------------------------------------------------
  function automatic plti_cmd_t make_cmd(logic mode, logic [plti_pkg::TSEL_W-1:0] tsel,
                                         logic [plti_pkg::IDX_W-1:0] idx,
                                         logic [plti_pkg::GAUGE_W-1:0] g,
                                         logic [plti_pkg::WEIGHT_W-1:0] w);
    plti_cmd_t c;
    c.mode        = mode;
    c.table_sel   = tsel;
    c.entry_index = idx;
    c.gauge       = g;
    c.weight      = w;
    return c;
  endfunction

  // query with random filler in the fields a query does not use
  function automatic plti_cmd_t make_query(logic [plti_pkg::TSEL_W-1:0] tsel,
                                           logic [plti_pkg::GAUGE_W-1:0] g);
    return make_cmd(plti_pkg::MODE_QUERY, tsel, plti_pkg::IDX_W'($urandom), g, $urandom);
  endfunction

  // one command transaction, with an optional idle burst ahead of it
  task automatic send_cmd(input plti_cmd_t c);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(0, 49) == 0) sender_calm = !sender_calm;
    if (!quiet && !sender_calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 5);
    if (gap != 0) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {4'b0, c.weight, c.gauge, c.entry_index};
    s_axis_tuser  = {c.table_sel, c.mode};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_command(c);
    if (c.mode == plti_pkg::MODE_LOAD && c.table_sel != plti_pkg::TSEL_NONE)
      loaded[c.table_sel][c.entry_index] = 1'b1;
  endtask

  // stop sending, wait for every result, then let the block settle
  task automatic drain();
    int unsigned waited;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [4:0] value);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    sb.set_count(idx, value);
  endtask

  function automatic logic [4:0] pick_count(int ph);
    case (ph)
      0: return 5'd16;
      1: return 5'd2;
      2: return $urandom_range(0, 1) ? 5'd0 : 5'd1;
      3: return $urandom_range(0, 1) ? 5'd31 : 5'd17;
      default: begin
        if ($urandom_range(0, 4) == 0) return 5'($urandom_range(0, 31));
        return 5'($urandom_range(2, 16));
      end
    endcase
  endfunction

  // every entry a query may walk has been loaded
  function automatic bit table_ready(int t);
    for (int i = 0; i < sb.table_count(t); i++)
      if (!loaded[t][i]) return 1'b0;
    return 1'b1;
  endfunction

  // sorted breakpoints with random content, now and then a repeated gauge
  task automatic fill_table(int t, int n);
    logic [plti_pkg::GAUGE_W-1:0]  step, g;
    logic [plti_pkg::WEIGHT_W-1:0] w;
    int                            style;
    step  = 24'hFFFFFF / n;
    style = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      g = plti_pkg::GAUGE_W'(i * step + $urandom_range(0, step - 1));
      if (i > 0 && $urandom_range(0, 15) == 0) g = sb.gauge_mem[t][i-1];
      case (style)
        0: w = $urandom;
        1: w = plti_pkg::WEIGHT_W'(i << 28) + $urandom_range(0, 32'h0FFF_FFFF);
        2: w = (i % 2 == 0) ? 32'h0 : 32'hFFFF_FFFF;
        default: w = $urandom_range(0, 4095);
      endcase
      send_cmd(make_cmd(plti_pkg::MODE_LOAD, plti_pkg::TSEL_W'(t), plti_pkg::IDX_W'(i),
                        g, w));
    end
  endtask

  // query gauges that land on, next to, between and outside the breakpoints
  function automatic logic [plti_pkg::GAUGE_W-1:0] pick_gauge(int t);
    int                           n, i;
    logic [plti_pkg::GAUGE_W-1:0] b;
    n = sb.table_count(t);
    i = $urandom_range(0, n - 1);
    b = sb.gauge_mem[t][i];
    case ($urandom_range(0, 9))
      0: return b;
      1: return b + 1'b1;
      2: return b - 1'b1;
      3: begin
        if (i + 1 < n)
          return plti_pkg::GAUGE_W'((25'(b) + 25'(sb.gauge_mem[t][i+1])) >> 1);
        return b;
      end
      4: return 24'hFFFFFF;
      5: return 24'd1;
      6: return 24'd0;
      default: return plti_pkg::GAUGE_W'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // directed start: zero gauge, exact hits, both anchors and the tie,
  // extrapolation both ways, saturation both ways, equal gauges, no table
  // --------------------------------------------------------------------------
  task automatic run_directed();
    // plain table: gentle rising line
    send_cmd(make_cmd(plti_pkg::MODE_LOAD, 2'd0, 4'd0, 24'h100000, 32'h1000_0000));
    send_cmd(make_cmd(plti_pkg::MODE_LOAD, 2'd0, 4'd1, 24'h200000, 32'h2000_0000));
    // wound table: steepest rise
    send_cmd(make_cmd(plti_pkg::MODE_LOAD, 2'd1, 4'd0, 24'h000001, 32'h0000_0000));
    send_cmd(make_cmd(plti_pkg::MODE_LOAD, 2'd1, 4'd1, 24'h000002, 32'hFFFF_FFFF));
    // heavy table: steepest fall
    send_cmd(make_cmd(plti_pkg::MODE_LOAD, 2'd2, 4'd0, 24'h000001, 32'hFFFF_FFFF));
    send_cmd(make_cmd(plti_pkg::MODE_LOAD, 2'd2, 4'd1, 24'h000002, 32'h0000_0000));
    // load into the missing table goes nowhere
    send_cmd(make_cmd(plti_pkg::MODE_LOAD, plti_pkg::TSEL_NONE, 4'd15, 24'hFFFFFF,
                      32'hFFFF_FFFF));
    send_cmd(make_query(2'd0, 24'h000000));
    send_cmd(make_query(2'd0, 24'h100000));
    send_cmd(make_query(2'd0, 24'h200000));
    send_cmd(make_query(2'd0, 24'h180000));
    send_cmd(make_query(2'd0, 24'h170000));
    send_cmd(make_query(2'd0, 24'h190000));
    send_cmd(make_query(2'd0, 24'h000001));
    send_cmd(make_query(2'd0, 24'hFFFFFF));
    send_cmd(make_query(2'd1, 24'hFFFFFF));
    send_cmd(make_query(2'd2, 24'hFFFFFF));
    send_cmd(make_query(2'd1, 24'h000003));
    send_cmd(make_query(plti_pkg::TSEL_NONE, 24'h123456));
    // both heavy breakpoints on one gauge: flat slope
    send_cmd(make_cmd(plti_pkg::MODE_LOAD, 2'd2, 4'd0, 24'h000002, 32'h0000_0007));
    send_cmd(make_query(2'd2, 24'h000002));
    send_cmd(make_query(2'd2, 24'h000009));
    send_cmd(make_query(2'd2, 24'h000001));
  endtask

  // mostly queries on loaded tables, some stray loads and empty-table queries
  task automatic send_random_item();
    int r, t;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      send_cmd(make_cmd(plti_pkg::MODE_LOAD, plti_pkg::TSEL_W'($urandom),
                        plti_pkg::IDX_W'($urandom), plti_pkg::GAUGE_W'($urandom),
                        $urandom));
    end else if (r < 16) begin
      send_cmd(make_query(plti_pkg::TSEL_NONE, plti_pkg::GAUGE_W'($urandom)));
    end else begin
      t = $urandom_range(0, plti_pkg::NUM_TABLES - 1);
      if (table_ready(t)) send_cmd(make_query(plti_pkg::TSEL_W'(t), pick_gauge(t)));
      else fill_table(t, sb.table_count(t));
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    sb          = new();
    quiet       = 1'b0;
    hold_sink   = 1'b0;
    sender_calm = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    run_directed();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // counts change only with nothing in flight
      drain();
      quiet = (ph == NUM_PHASES - 1);
      write_cfg(plti_pkg::CFG_COUNT_PLAIN, pick_count(ph));
      write_cfg(plti_pkg::CFG_COUNT_WOUND, pick_count(ph));
      write_cfg(plti_pkg::CFG_COUNT_HEAVY, pick_count(ph));
      if (ph == 3) write_cfg(CFG_IDX_UNUSED, 5'($urandom));
      for (int t = 0; t < plti_pkg::NUM_TABLES; t++)
        if (!table_ready(t) || $urandom_range(0, 2) != 0) fill_table(t, sb.table_count(t));
      if (ph == 2) hold_sink = 1'b1;
      repeat (ITEMS_PER_PHASE) send_random_item();
    end

    drain();
    if (sb.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
